// ===== rtl/ipsm_pkg.sv =====
package ipsm_pkg;

  // Widths of the data path.
  localparam int DATA_W       = 64;
  localparam int HALF_W       = DATA_W / 2;
  localparam int EXP_W_MAX    = 63;
  localparam int EXP_BITS_DEF = 63;

  // Widths of the streaming buses, in bits.
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = DATA_W;

  // One item as it travels between exponent-bit steps.
  // acc holds the running product, sq the base raised to 2^k, and expo the
  // exponent bits that are still to be consumed, lowest bit next.
  typedef struct packed {
    logic                 vld;
    logic [DATA_W-1:0]    acc;
    logic [DATA_W-1:0]    sq;
    logic [EXP_W_MAX-1:0] expo;
  } ipsm_item_t;

endpackage

// ===== rtl/ipsm_step.sv =====
// One exponent bit of right-to-left square-and-multiply, in two register
// stages: 32x32 partial products first, then the sums that form the wrapped
// 64-bit products.
module ipsm_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ipsm_pkg::ipsm_item_t item_i,
  output ipsm_pkg::ipsm_item_t item_o
);

  localparam int DW = ipsm_pkg::DATA_W;
  localparam int HW = ipsm_pkg::HALF_W;

  // Partial products held between the two stages.
  typedef struct packed {
    logic                           vld;
    logic                           mul;
    logic [DW-1:0]                  acc;
    logic [DW-1:0]                  a_ll;
    logic [HW-1:0]                  a_lh;
    logic [HW-1:0]                  a_hl;
    logic [DW-1:0]                  s_ll;
    logic [HW-1:0]                  s_x;
    logic [ipsm_pkg::EXP_W_MAX-1:0] expo;
  } part_t;

  part_t                s1_r;
  part_t                s1_nxt;
  ipsm_pkg::ipsm_item_t s2_r;
  ipsm_pkg::ipsm_item_t s2_nxt;

  logic [HW-1:0] acc_lo;
  logic [HW-1:0] acc_hi;
  logic [HW-1:0] sq_lo;
  logic [HW-1:0] sq_hi;
  logic [HW-1:0] a_cross;
  logic [HW-1:0] s_cross;

  assign acc_lo = item_i.acc[HW-1:0];
  assign acc_hi = item_i.acc[DW-1:HW];
  assign sq_lo  = item_i.sq[HW-1:0];
  assign sq_hi  = item_i.sq[DW-1:HW];

  // Stage 1: the partial products of acc*sq and sq*sq. Cross terms only
  // matter in their low half, since the high half falls off the 64-bit word.
  always_comb begin
    s1_nxt.vld  = item_i.vld;
    s1_nxt.mul  = item_i.expo[0];
    s1_nxt.acc  = item_i.acc;
    s1_nxt.a_ll = DW'(acc_lo) * DW'(sq_lo);
    s1_nxt.a_lh = acc_lo * sq_hi;
    s1_nxt.a_hl = acc_hi * sq_lo;
    s1_nxt.s_ll = DW'(sq_lo) * DW'(sq_lo);
    s1_nxt.s_x  = sq_lo * sq_hi;
    s1_nxt.expo = item_i.expo >> 1;
  end

  // Stage 2: add the partial products; the accumulator takes the product
  // only when the current exponent bit is set.
  always_comb begin
    a_cross     = s1_r.a_lh + s1_r.a_hl;
    s_cross     = s1_r.s_x << 1;
    s2_nxt.vld  = s1_r.vld;
    s2_nxt.acc  = s1_r.mul ? (s1_r.a_ll + {a_cross, {HW{1'b0}}}) : s1_r.acc;
    s2_nxt.sq   = s1_r.s_ll + {s_cross, {HW{1'b0}}};
    s2_nxt.expo = s1_r.expo;
  end

  // Valid bits are reset; the payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s1_r.vld <= s1_nxt.vld;
      s2_r.vld <= s2_nxt.vld;
    end
    if (en) begin
      s1_r.mul  <= s1_nxt.mul;
      s1_r.acc  <= s1_nxt.acc;
      s1_r.a_ll <= s1_nxt.a_ll;
      s1_r.a_lh <= s1_nxt.a_lh;
      s1_r.a_hl <= s1_nxt.a_hl;
      s1_r.s_ll <= s1_nxt.s_ll;
      s1_r.s_x  <= s1_nxt.s_x;
      s1_r.expo <= s1_nxt.expo;
      s2_r.acc  <= s2_nxt.acc;
      s2_r.sq   <= s2_nxt.sq;
      s2_r.expo <= s2_nxt.expo;
    end
  end

  assign item_o = s2_r;

endmodule

// ===== rtl/integer_power_square_multiply.sv =====
// Raises a signed 64-bit base to a signed 64-bit exponent, wrapping modulo
// 2^64 in two's complement; a negative exponent gives 0 and a zero exponent
// gives 1. The block takes one request every cycle while the skid register
// is empty and returns each result in order: every scanned exponent bit has
// one step of two register stages, 32x32 partial products followed by their
// sum, and one output register follows the last step. A skid register behind
// the output catches the result that leaves the pipeline during a stall;
// in_tready drops while it is occupied.
module integer_power_square_multiply #(
  parameter int EXP_BITS = ipsm_pkg::EXP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] base, [127:64] exponent
  input  logic [ipsm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] power
  output logic [ipsm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DW = ipsm_pkg::DATA_W;
  localparam int EW = ipsm_pkg::EXP_W_MAX;

  ipsm_pkg::ipsm_item_t stage_d [EXP_BITS+1];

  logic          en;
  logic [DW-1:0] base;
  logic [DW-1:0] expo_in;
  logic          neg;
  logic          last_vld;

  logic          out_vld_r;
  logic          out_vld_nxt;
  logic [DW-1:0] out_dat_r;
  logic [DW-1:0] out_dat_nxt;
  logic          skid_vld_r;
  logic          skid_vld_nxt;
  logic [DW-1:0] skid_dat_r;
  logic [DW-1:0] skid_dat_nxt;

  // The whole pipeline moves together while the skid register is empty.
  assign en        = !skid_vld_r;
  assign in_tready = en;

  assign base    = in_tdata[DW-1:0];
  assign expo_in = in_tdata[2*DW-1:DW];
  assign neg     = expo_in[DW-1];

  // A negative exponent enters with accumulator 0 and no exponent bits.
  always_comb begin
    stage_d[0].vld  = in_tvalid;
    stage_d[0].acc  = neg ? '0 : DW'(1);
    stage_d[0].sq   = base;
    stage_d[0].expo = neg ? '0 : EW'(expo_in[EXP_BITS-1:0]);
  end

  // One step per scanned exponent bit, lowest bit first.
  for (genvar i = 0; i < EXP_BITS; i++) begin : g_step
    ipsm_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .item_i (stage_d[i]),
      .item_o (stage_d[i+1])
    );
  end

  assign last_vld = stage_d[EXP_BITS].vld && en;

  // Output register with a skid register behind it.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_dat_nxt  = out_dat_r;
    skid_vld_nxt = skid_vld_r;
    skid_dat_nxt = skid_dat_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_dat_nxt  = skid_dat_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = last_vld;
        out_dat_nxt = stage_d[EXP_BITS].acc;
      end
    end else if (last_vld) begin
      skid_vld_nxt = 1'b1;
      skid_dat_nxt = stage_d[EXP_BITS].acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    skid_dat_r <= skid_dat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  // The skid register is only ever filled behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a result while the output is empty");

  // A result leaving the pipeline during a stall lands in the skid register.
  a_stall_catch : assert property (@(posedge clk) disable iff (!rst_n)
    (last_vld && out_vld_r && !out_tready) |=> skid_vld_r)
    else $error("result lost while the output was stalled");

  // A parked result moves to the output as soon as the output is taken.
  a_skid_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (out_vld_r && !skid_vld_r))
    else $error("skid register did not drain into the output");

  // While the skid register is full and the output waits, nothing moves.
  a_skid_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_tready) |=> (skid_vld_r && $stable(skid_dat_r)))
    else $error("skid register changed during a stall");

endmodule
